// ===== design/image_2x_midpoint_upsampler_unit_defines.svh =====
// assertion macros used by the upsampler rtl
`ifndef IMAGE_2X_MIDPOINT_UPSAMPLER_UNIT_DEFINES_SVH
`define IMAGE_2X_MIDPOINT_UPSAMPLER_UNIT_DEFINES_SVH

// property checked at every rising clock edge, off while reset is low
`define I2XU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define I2XU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/i2xu_pkg.sv =====
// types and constants shared by the upsampler modules
`default_nettype none
package i2xu_pkg;

  localparam int PIX_W   = 16;
  localparam int CFG_W   = 13;
  localparam int ROW_W   = 12;
  localparam int COORD_W = 13;

  // size limits of the image registers
  localparam logic [CFG_W-1:0] SIZE_LO  = 13'd2;
  localparam logic [CFG_W-1:0] ROWS_HI  = 13'd4096;
  localparam int               CFG_MAX  = 8191;

  // configuration register indexes
  localparam logic [0:0] REG_IMAGE_ROWS = 1'b0;
  localparam logic [0:0] REG_IMAGE_COLS = 1'b1;

  // bit positions of the result kinds in the pending mask, in emit order
  localparam int KIND_COPY   = 0;
  localparam int KIND_VERT   = 1;
  localparam int KIND_HORIZ  = 2;
  localparam int KIND_CENTRE = 3;
  localparam int KIND_N      = 4;

  // accepted pixel with its input position
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [ROW_W-1:0]   row;
    logic [COORD_W-1:0] col;
    logic               done;
  } pix_info_t;

  // one output sample
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   value;
    logic               run_last;
    logic               image_done;
  } result_t;

endpackage
`default_nettype wire

// ===== design/image_2x_midpoint_upsampler_unit.sv =====
// 2x midpoint upsampler: pixel word in, 1 to 4 output samples out per pixel
// the first sample of a pixel passes the pixel stage, then the output register,
//   to reach out_tvalid, and is held back while the output register is held
// a pixel's samples leave on the single result channel; the next pixel enters
//   as the last issues; the line buffer ram does one read and one write per pixel
// reset: synchronous active-low rst_n sets size to 2x2 and position to (0,0);
//   the line buffer is not cleared, row 0 never uses what it reads
`default_nettype none
module image_2x_midpoint_upsampler_unit
  import i2xu_pkg::*;
#(
  parameter int MAX_COLS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // in_tdata: pixel_value[15:0]
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,
  // out_tdata: out_row[12:0], out_col[25:13], out_value[41:26], zero[47:42]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [47:0]       out_tdata,
  output logic                   out_tlast,
  // out_tuser: image_done[0]
  output logic                   out_tuser,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_COLS);

  logic              in_accept;
  pix_info_t         info;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;
  logic [PIX_W-1:0]  wr_data, up_data;
  result_t           res;

  assign in_accept = in_tvalid && in_tready;

  // position and size control
  i2xu_ctrl #(
    .MAX_COLS (MAX_COLS),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (in_accept),
    .pixel     (in_tdata),
    .info      (info),
    .rd_addr   (rd_addr)
  );

  // previous row line buffer
  i2xu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (up_data)
  );

  // pixel stage and output register
  i2xu_emit #(
    .ADDR_W (ADDR_W)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .info      (info),
    .rd_addr   (rd_addr),
    .up_data   (up_data),
    .ready     (in_tready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the output word
  assign out_tdata = {6'b0, res.value, res.col, res.row};
  assign out_tlast = res.run_last;
  assign out_tuser = res.image_done;

endmodule
`default_nettype wire

// ===== design/i2xu_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module i2xu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, output holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/i2xu_ctrl.sv =====
// image size registers, raster position counters and line buffer read address
`default_nettype none
module i2xu_ctrl
  import i2xu_pkg::*;
#(
  parameter int MAX_COLS = 4096,
  parameter int ADDR_W   = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              accept,
  input  wire logic [PIX_W-1:0]  pixel,
  output pix_info_t              info,
  output logic      [ADDR_W-1:0] rd_addr
);

  localparam int               COL_HI_I = (MAX_COLS > CFG_MAX) ? CFG_MAX : MAX_COLS;
  localparam logic [CFG_W-1:0] COL_HI   = CFG_W'(COL_HI_I);

  logic [CFG_W-1:0]   rows_cfg_r, rows_cfg_nxt;
  logic [CFG_W-1:0]   cols_cfg_r, cols_cfg_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [CFG_W-1:0]   rows_eff, cols_eff;
  logic               last_row, last_col;

  // clamp the sizes into their legal ranges
  always_comb begin
    if (rows_cfg_r < SIZE_LO) begin
      rows_eff = SIZE_LO;
    end else if (rows_cfg_r > ROWS_HI) begin
      rows_eff = ROWS_HI;
    end else begin
      rows_eff = rows_cfg_r;
    end
    if (cols_cfg_r < SIZE_LO) begin
      cols_eff = SIZE_LO;
    end else if (cols_cfg_r > COL_HI) begin
      cols_eff = COL_HI;
    end else begin
      cols_eff = cols_cfg_r;
    end
  end

  assign last_row = ({1'b0, row_r} == (rows_eff - 13'd1));
  assign last_col = (col_r == (cols_eff - 13'd1));

  // next position, config writes restart the image
  always_comb begin
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_ROWS: rows_cfg_nxt = cfg_wdata;
        REG_IMAGE_COLS: cols_cfg_nxt = cfg_wdata;
        default:        ;
      endcase
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 12'd1;
      end else begin
        col_nxt = col_r + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= SIZE_LO;
      cols_cfg_r <= SIZE_LO;
      row_r      <= '0;
      col_r      <= '0;
    end else begin
      rows_cfg_r <= rows_cfg_nxt;
      cols_cfg_r <= cols_cfg_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
    end
  end

  // current pixel with its position
  assign info.pixel = pixel;
  assign info.row   = row_r;
  assign info.col   = col_r;
  assign info.done  = last_row && last_col;
  assign rd_addr    = ADDR_W'(col_r);

endmodule
`default_nettype wire

// ===== design/i2xu_emit.sv =====
// pixel stage: line buffer write-back, sample arithmetic and output register
`default_nettype none
`include "image_2x_midpoint_upsampler_unit_defines.svh"
module i2xu_emit
  import i2xu_pkg::*;
#(
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  pix_info_t              info,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [PIX_W-1:0]  up_data,
  output logic                   ready,
  output logic                   wr_en,
  output logic      [ADDR_W-1:0] wr_addr,
  output logic      [PIX_W-1:0]  wr_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output result_t                res
);

  pix_info_t         info_r;
  logic [KIND_N-1:0] mask_r, mask_nxt;
  logic              busy_r, busy_nxt;
  logic              first_r;
  logic [PIX_W-1:0]  left_r, ul_r;
  logic              ovalid_r, ovalid_nxt;
  result_t           oreg_r;

  logic [KIND_N-1:0]  sel, rem;
  logic               issue, last;
  logic [COORD_W-1:0] row2, col2;
  logic [PIX_W:0]     sum_v, sum_h;
  logic [PIX_W+1:0]   sum_c;
  result_t            cur;

  // lowest pending kind goes next
  assign sel   = mask_r & (~mask_r + 4'd1);
  assign rem   = mask_r & ~sel;
  assign last  = (rem == '0);
  assign issue = busy_r && (!ovalid_r || res_ready);
  assign ready = !busy_r || (issue && last);

  // line buffer write-back in the pixel's first cycle
  assign wr_en   = first_r;
  assign wr_addr = ADDR_W'(info_r.col);
  assign wr_data = info_r.pixel;

  // sample arithmetic
  assign row2  = {info_r.row, 1'b0};
  assign col2  = {info_r.col[COORD_W-2:0], 1'b0};
  assign sum_v = {1'b0, up_data} + {1'b0, info_r.pixel};
  assign sum_h = {1'b0, left_r} + {1'b0, info_r.pixel};
  assign sum_c = {2'b00, ul_r} + {2'b00, up_data} + {2'b00, left_r} + {2'b00, info_r.pixel};

  always_comb begin
    cur.row        = row2;
    cur.col        = col2;
    cur.value      = info_r.pixel;
    cur.run_last   = last;
    cur.image_done = last && info_r.done;
    if (sel[KIND_VERT]) begin
      cur.row   = row2 - 13'd1;
      cur.value = sum_v[PIX_W:1];
    end else if (sel[KIND_HORIZ]) begin
      cur.col   = col2 - 13'd1;
      cur.value = sum_h[PIX_W:1];
    end else if (sel[KIND_CENTRE]) begin
      cur.row   = row2 - 13'd1;
      cur.col   = col2 - 13'd1;
      cur.value = sum_c[PIX_W+1:2];
    end
  end

  // pending mask and busy flag
  always_comb begin
    mask_nxt   = mask_r;
    busy_nxt   = busy_r;
    ovalid_nxt = ovalid_r;
    if (issue) begin
      mask_nxt   = rem;
      ovalid_nxt = 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end else if (res_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt                = 1'b1;
      mask_nxt                = '0;
      mask_nxt[KIND_COPY]     = 1'b1;
      mask_nxt[KIND_VERT]     = (info.row != '0);
      mask_nxt[KIND_HORIZ]    = (info.col != '0);
      mask_nxt[KIND_CENTRE]   = (info.row != '0) && (info.col != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      busy_r   <= 1'b0;
      first_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      mask_r   <= mask_nxt;
      busy_r   <= busy_nxt;
      first_r  <= accept;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      info_r <= info;
    end
    if (issue) begin
      oreg_r <= cur;
    end
    if (issue && last) begin
      left_r <= info_r.pixel;
      ul_r   <= up_data;
    end
  end

  assign res_valid = ovalid_r;
  assign res       = oreg_r;

  `I2XU_ASSERT(a_mask_live, busy_r |-> (mask_r != '0), "busy pixel has no pending result")
  `I2XU_ASSERT_NEXT(a_load, accept, busy_r && first_r && mask_r[KIND_COPY],
                    "accepted pixel not loaded with its copy pending")
  `I2XU_ASSERT(a_rw_apart, (wr_en && accept) |-> (wr_addr != rd_addr),
               "line buffer read and write hit the same entry")
  `I2XU_ASSERT(a_done_last, (ovalid_r && oreg_r.image_done) |-> oreg_r.run_last,
               "image end flagged on a result that is not the pixel's last")

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for the 2x midpoint upsampler: table-driven and random pixels
`default_nettype none
module tb_top
  import i2xu_pkg::*;
();

  localparam int MAX_COLS   = 4096;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 12;
  localparam int SHOW_MAX   = 10;

  // kinds of rows in the directed table
  typedef enum logic [1:0] {
    DIR_PIX,
    DIR_ROWS,
    DIR_COLS
  } dir_kind_t;

  typedef struct packed {
    dir_kind_t        kind;
    logic [15:0]      data;
    logic             typed;
    logic [PIX_W-1:0] tval;
  } dir_row_t;

  localparam int DIR_N = 31;

  // pixel rows with typed set carry the value every sample of that pixel must have
  localparam dir_row_t DIR_TAB [0:DIR_N-1] = '{
    // reset size 2x2, all ones then all zeros
    '{DIR_PIX,  16'hFFFF, 1'b1, 16'hFFFF},
    '{DIR_PIX,  16'hFFFF, 1'b1, 16'hFFFF},
    '{DIR_PIX,  16'hFFFF, 1'b1, 16'hFFFF},
    '{DIR_PIX,  16'hFFFF, 1'b1, 16'hFFFF},
    '{DIR_PIX,  16'h0000, 1'b1, 16'h0000},
    '{DIR_PIX,  16'h0000, 1'b1, 16'h0000},
    '{DIR_PIX,  16'h0000, 1'b1, 16'h0000},
    '{DIR_PIX,  16'h0000, 1'b1, 16'h0000},
    // truncation of the means
    '{DIR_PIX,  16'hFFFF, 1'b0, 16'h0000},
    '{DIR_PIX,  16'h0001, 1'b0, 16'h0000},
    '{DIR_PIX,  16'h8000, 1'b0, 16'h0000},
    '{DIR_PIX,  16'h7FFF, 1'b0, 16'h0000},
    // sizes below range clamp to 2x2
    '{DIR_ROWS, 16'h0000, 1'b0, 16'h0000},
    '{DIR_COLS, 16'h0001, 1'b0, 16'h0000},
    '{DIR_PIX,  16'hAAAA, 1'b1, 16'hAAAA},
    '{DIR_PIX,  16'hAAAA, 1'b1, 16'hAAAA},
    '{DIR_PIX,  16'hAAAA, 1'b1, 16'hAAAA},
    '{DIR_PIX,  16'hAAAA, 1'b1, 16'hAAAA},
    // column count above range clamps to the buffer depth
    '{DIR_ROWS, 16'h0003, 1'b0, 16'h0000},
    '{DIR_COLS, 16'h1FFF, 1'b0, 16'h0000},
    '{DIR_PIX,  16'hFFFF, 1'b0, 16'h0000},
    '{DIR_PIX,  16'hFFFF, 1'b0, 16'h0000},
    '{DIR_PIX,  16'h0000, 1'b0, 16'h0000},
    '{DIR_PIX,  16'h0001, 1'b0, 16'h0000},
    // 3x3 image, second row reaches the vertical and centre samples
    '{DIR_COLS, 16'h0003, 1'b0, 16'h0000},
    '{DIR_PIX,  16'hFFFF, 1'b0, 16'h0000},
    '{DIR_PIX,  16'hFFFE, 1'b0, 16'h0000},
    '{DIR_PIX,  16'h0001, 1'b0, 16'h0000},
    '{DIR_PIX,  16'h0000, 1'b0, 16'h0000},
    '{DIR_PIX,  16'hFFFF, 1'b0, 16'h0000},
    '{DIR_PIX,  16'h7FFF, 1'b0, 16'h0000}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [15:0]      in_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;
  logic             out_tlast;
  logic             out_tuser;
  logic             cfg_we;
  logic [0:0]       cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  // predictor state
  logic [PIX_W-1:0] line_buf [0:MAX_COLS-1];
  logic [PIX_W-1:0] left_px;
  logic [PIX_W-1:0] upleft_px;
  int               cur_row;
  int               cur_col;
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;

  result_t expected_samples [$];
  int      err_cnt;
  int      idle_cycles;
  bit      no_idle;

  image_2x_midpoint_upsampler_unit #(
    .MAX_COLS(MAX_COLS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return PIX_W'($urandom());
  endfunction

  function automatic int clamp_size(logic [CFG_W-1:0] v, int hi);
    if (int'(v) < int'(SIZE_LO)) return int'(SIZE_LO);
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic result_t make_sample(int r, int c, int v);
    result_t s;
    s.row        = COORD_W'(r);
    s.col        = COORD_W'(c);
    s.value      = PIX_W'(v);
    s.run_last   = 1'b0;
    s.image_done = 1'b0;
    return s;
  endfunction

  task automatic restart_pos();
    cur_row   = 0;
    cur_col   = 0;
    left_px   = '0;
    upleft_px = '0;
  endtask

  // expected samples of one accepted pixel, in emit order
  task automatic predict_pixel(input logic [PIX_W-1:0] px, input bit typed,
                               input logic [PIX_W-1:0] tval);
    int      rows;
    int      cols;
    int      r;
    int      c;
    int      p;
    int      up;
    int      lf;
    int      ul;
    int      n;
    result_t smp [4];
    rows = clamp_size(rows_reg, int'(ROWS_HI));
    cols = clamp_size(cols_reg, MAX_COLS);
    if (cur_row >= rows || cur_col >= cols) restart_pos();
    r  = cur_row;
    c  = cur_col;
    p  = int'(px);
    up = int'(line_buf[c]);
    lf = int'(left_px);
    ul = int'(upleft_px);
    n  = 0;
    smp[n] = make_sample(2 * r, 2 * c, typed ? int'(tval) : p);
    n++;
    if (r > 0) begin
      smp[n] = make_sample(2 * r - 1, 2 * c, typed ? int'(tval) : (up + p) >> 1);
      n++;
    end
    if (c > 0) begin
      smp[n] = make_sample(2 * r, 2 * c - 1, typed ? int'(tval) : (lf + p) >> 1);
      n++;
    end
    if (r > 0 && c > 0) begin
      smp[n] = make_sample(2 * r - 1, 2 * c - 1,
                           typed ? int'(tval) : (ul + up + lf + p) >> 2);
      n++;
    end
    smp[n-1].run_last   = 1'b1;
    smp[n-1].image_done = (r == rows - 1) && (c == cols - 1);
    for (int i = 0; i < n; i++) expected_samples.push_back(smp[i]);
    // advance line buffer, neighbors and position
    line_buf[c] = px;
    upleft_px   = PIX_W'(up);
    left_px     = px;
    if (c + 1 >= cols) begin
      cur_col = 0;
      if (r + 1 >= rows) restart_pos();
      else cur_row = r + 1;
    end else begin
      cur_col = c + 1;
    end
  endtask

  task automatic note_fail(input string msg);
    if (err_cnt < SHOW_MAX) $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  // one pixel word, predicted at acceptance
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                            input logic [PIX_W-1:0] tval);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    predict_pixel(px, typed, tval);
  endtask

  // register write once the block has drained
  task automatic write_reg(input logic [0:0] addr, input logic [CFG_W-1:0] val);
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_IMAGE_ROWS) rows_reg = val;
    else cols_reg = val;
    restart_pos();
  endtask

  task automatic set_size(input logic [CFG_W-1:0] rows_val,
                          input logic [CFG_W-1:0] cols_val);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_IMAGE_ROWS, rows_val);
      write_reg(REG_IMAGE_COLS, cols_val);
    end else begin
      write_reg(REG_IMAGE_COLS, cols_val);
      write_reg(REG_IMAGE_ROWS, rows_val);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_size(int hi_small);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return CFG_W'($urandom_range(0, 1));
    if (sel == 1) return CFG_W'($urandom_range(4097, CFG_MAX));
    return CFG_W'($urandom_range(2, hi_small));
  endfunction

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (no_idle || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_tready <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.row        = out_tdata[12:0];
      got.col        = out_tdata[25:13];
      got.value      = out_tdata[41:26];
      got.run_last   = out_tlast;
      got.image_done = out_tuser;
      if (expected_samples.size() == 0) begin
        note_fail($sformatf("unexpected word row=%0d col=%0d value=%h",
                            got.row, got.col, got.value));
      end else begin
        want = expected_samples.pop_front();
        if (got != want || out_tdata[47:42] != '0) begin
          note_fail($sformatf({"sample mismatch: exp row=%0d col=%0d value=%h last=%b done=%b",
                               " got row=%0d col=%0d value=%h last=%b done=%b pad=%h"},
                              want.row, want.col, want.value, want.run_last,
                              want.image_done, got.row, got.col, got.value,
                              got.run_last, got.image_done, out_tdata[47:42]));
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int rows;
    int cols;
    int n_items;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_addr    = REG_IMAGE_ROWS;
    cfg_wdata   = '0;
    err_cnt     = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    rows_reg    = SIZE_LO;
    cols_reg    = SIZE_LO;
    for (int i = 0; i < MAX_COLS; i++) line_buf[i] = '0;
    restart_pos();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      case (DIR_TAB[i].kind)
        DIR_PIX:  send_pixel(DIR_TAB[i].data, DIR_TAB[i].typed, DIR_TAB[i].tval);
        DIR_ROWS: write_reg(REG_IMAGE_ROWS, CFG_W'(DIR_TAB[i].data));
        DIR_COLS: write_reg(REG_IMAGE_COLS, CFG_W'(DIR_TAB[i].data));
        default: ;
      endcase
    end

    // random small images, mostly whole ones plus a few wrapping pixels
    for (int ph = 0; ph < 3; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      set_size(pick_size(5), pick_size(8));
      rows = clamp_size(rows_reg, int'(ROWS_HI));
      cols = clamp_size(cols_reg, MAX_COLS);
      if (rows * cols <= 40) n_items = rows * cols + $urandom_range(0, 4);
      else n_items = $urandom_range(8, 20);
      for (int k = 0; k < n_items; k++) send_pixel(pick_pixel(), 1'b0, '0);
    end

    // widest image: start of the first row
    no_idle = 1'b0;
    set_size(CFG_W'(2), CFG_W'(MAX_COLS));
    for (int k = 0; k < 8; k++) send_pixel(pick_pixel(), 1'b0, '0);

    // tallest image: first rows
    set_size(CFG_W'(4096), CFG_W'(2));
    for (int k = 0; k < 8; k++) send_pixel(pick_pixel(), 1'b0, '0);

    // drain and finish
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_samples.size() != 0)
      note_fail($sformatf("%0d samples never arrived", expected_samples.size()));
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
